// ----- rtl/pph_pkg.sv -----
// package for the proxy protocol header parser
// holds the request and result payload types and protocol constants
package pph_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } pph_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  version;
        logic [16:0] header_length;
        logic [1:0]  addr_kind;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] src_port;
        logic [6:0]  text_offset;
        logic [6:0]  text_length;
    } pph_out_t;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_NOT_PROXY = 2'd2;

    localparam logic [1:0] VER_UNKNOWN = 2'd0;
    localparam logic [1:0] VER_TEXT = 2'd1;
    localparam logic [1:0] VER_BINARY = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;
    localparam logic [1:0] KIND_V4 = 2'd2;
    localparam logic [1:0] KIND_V6 = 2'd3;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_V2_HEAD = 3'd1;
    localparam logic [2:0] PH_V2_BLOCK = 3'd2;
    localparam logic [2:0] PH_V1 = 3'd3;
    localparam logic [2:0] PH_FIN = 3'd4;

    localparam int V1_MAX_LEN = 107;
    localparam int V2_FIXED_LEN = 16;
    localparam int SIG_LEN = 12;

    localparam logic [2:0] PM_FULL = 3'd4;
    localparam logic [2:0] PM_BAD = 3'd7;

    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] r;
        begin
            unique case (idx)
                4'd0, 4'd2, 4'd5: r = 8'h0D;
                4'd1, 4'd3, 4'd6, 4'd11: r = 8'h0A;
                4'd4: r = 8'h00;
                4'd7: r = 8'h51;
                4'd8: r = 8'h55;
                4'd9: r = 8'h49;
                4'd10: r = 8'h54;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
        logic [7:0] r;
        begin
            unique case (idx)
                3'd0: r = 8'h50;
                3'd1: r = 8'h52;
                3'd2: r = 8'h4F;
                3'd3: r = 8'h58;
                3'd4: r = 8'h59;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/pph_core.sv -----
// per-byte parse state and verdict logic for the proxy header parser
// depends on pph_pkg
module pph_core import pph_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    input  pph_in_t  in_data,
    output logic     res_valid,
    output pph_out_t res_data
);

    logic [2:0]  phase_reg, phase_next;
    logic [16:0] count_reg, count_next;
    logic        cr_reg, cr_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic [3:0]  fam_reg, fam_next;
    logic        vbad_reg, vbad_next;
    logic [15:0] blen_reg, blen_next;
    logic [7:0]  addr_reg [16];
    logic [15:0] p4_reg, p4_next;
    logic [15:0] p6_reg, p6_next;
    logic [2:0]  fidx_reg, fidx_next;
    logic [2:0]  pm_reg, pm_next;
    logic [6:0]  tst_reg, tst_next;
    logic [6:0]  tln_reg, tln_next;
    logic [15:0] pacc_reg, pacc_next;
    logic        povf_reg, povf_next;
    logic        pdone_reg, pdone_next;

    logic        wr_en;
    logic [3:0]  wr_idx;

    logic [7:0]  b;
    logic [16:0] pos;
    logic [16:0] off;
    logic [63:0] pk_hi, pk_lo;
    logic        eff_start;

    logic [16:0] v2_len;
    logic [16:0] cnt_inc;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            pk_hi[63 - 8*i -: 8] = addr_reg[i];
            pk_lo[63 - 8*i -: 8] = addr_reg[i + 8];
        end
    end

    // one text char step; chained twice when a held cr is replayed
    function automatic void text_step(
        input logic [7:0] ch, input logic [6:0] p,
        inout logic [2:0] fi, inout logic [2:0] pm, inout logic [6:0] ts,
        inout logic [6:0] tl, inout logic [15:0] acc, inout logic ovf,
        inout logic dn);
        logic [19:0] v;
        logic        ok;
        begin
            v = 20'(acc) * 20'd10 + 20'(ch - 8'h30);
            ok = 1'b0;
            if (ch == 8'h20) begin
                if (fi != 3'd7) fi = fi + 3'd1;
                if (fi == 3'd2) ts = p + 7'd1;
            end else if (fi == 3'd1) begin
                if (pm < PM_FULL) begin
                    unique case (pm)
                        3'd0: ok = (ch == 8'h54);
                        3'd1: ok = (ch == 8'h43);
                        3'd2: ok = (ch == 8'h50);
                        default: ok = (ch == 8'h34) || (ch == 8'h36);
                    endcase
                    pm = ok ? pm + 3'd1 : PM_BAD;
                end else begin
                    pm = PM_BAD;
                end
            end else if (fi == 3'd2) begin
                tl = tl + 7'd1;
            end else if (fi == 3'd4 && !dn) begin
                if (ch >= 8'h30 && ch <= 8'h39) begin
                    if (!ovf) begin
                        if (v > 20'd65535) ovf = 1'b1;
                        else acc = v[15:0];
                    end
                end else begin
                    dn = 1'b1;
                end
            end
        end
    endfunction

    always_comb begin
        logic [2:0]  ph;
        logic [2:0]  fi;
        logic [2:0]  pm;
        logic [6:0]  ts;
        logic [6:0]  tl;
        logic [15:0] acc;
        logic        ovf;
        logic        dn;
        logic [16:0] base_cnt;
        logic        live;
        b = in_data.data_byte;
        eff_start = in_data.start_req;
        res_valid = 1'b0;
        res_data = '0;
        wr_en = 1'b0;
        wr_idx = '0;
        phase_next = phase_reg;
        count_next = count_reg;
        cr_next = cr_reg;
        cmd_next = cmd_reg;
        fam_next = fam_reg;
        vbad_next = vbad_reg;
        blen_next = blen_reg;
        p4_next = p4_reg;
        p6_next = p6_reg;
        fi = fidx_reg;
        pm = pm_reg;
        ts = tst_reg;
        tl = tln_reg;
        acc = pacc_reg;
        ovf = povf_reg;
        dn = pdone_reg;
        ph = phase_reg;
        base_cnt = count_reg;
        live = 1'b1;
        if (eff_start) begin
            cr_next = 1'b0; cmd_next = '0; fam_next = '0; vbad_next = 1'b0;
            blen_next = '0; p4_next = '0; p6_next = '0;
            fi = '0; pm = '0; ts = '0; tl = '0; acc = '0; ovf = 1'b0; dn = 1'b0;
            base_cnt = '0;
            if (b == sig_byte(4'd0)) ph = PH_V2_HEAD;
            else if (b == prefix_byte(3'd0)) ph = PH_V1;
            else begin
                ph = PH_FIN;
                live = 1'b0;
                res_valid = 1'b1;
                res_data.status = ST_NOT_PROXY;
            end
        end else if (phase_reg == PH_IDLE || phase_reg == PH_FIN) begin
            live = 1'b0;
        end
        pos = base_cnt;
        off = base_cnt - 17'(V2_FIXED_LEN);
        cnt_inc = base_cnt + 17'd1;
        v2_len = 17'(V2_FIXED_LEN) + 17'(blen_next);
        count_next = base_cnt;
        phase_next = ph;
        if (live) begin
            if (ph == PH_V1) begin
                if (pos < 17'd5) begin
                    if (b != prefix_byte(pos[2:0])) begin
                        live = 1'b0;
                        phase_next = PH_FIN;
                        res_valid = 1'b1;
                        res_data.status = ST_NOT_PROXY;
                    end else begin
                        text_step(b, pos[6:0], fi, pm, ts, tl, acc, ovf, dn);
                    end
                end else begin
                    if (cr_next && b == 8'h0A) begin
                        live = 1'b0;
                        phase_next = PH_FIN;
                        res_valid = 1'b1;
                        res_data.version = VER_TEXT;
                        res_data.header_length = cnt_inc;
                        if (fi >= 3'd4 && pm == PM_FULL) begin
                            res_data.addr_kind = KIND_TEXT;
                            res_data.src_port = ovf ? 16'd0 : acc;
                            res_data.text_offset = ts;
                            res_data.text_length = tl;
                        end
                    end else begin
                        if (cr_next) begin
                            text_step(8'h0D, 7'(pos - 17'd1), fi, pm, ts, tl, acc, ovf,
                                      dn);
                            cr_next = 1'b0;
                        end
                        if (b == 8'h0D) cr_next = 1'b1;
                        else text_step(b, pos[6:0], fi, pm, ts, tl, acc, ovf, dn);
                    end
                end
                if (live) begin
                    count_next = cnt_inc;
                    if (cnt_inc > 17'(V1_MAX_LEN)) begin
                        phase_next = PH_FIN;
                        res_valid = 1'b1;
                        res_data.status = ST_INVALID;
                        res_data.version = VER_TEXT;
                    end
                end
            end else if (ph == PH_V2_HEAD) begin
                count_next = cnt_inc;
                if (pos < 17'(SIG_LEN)) begin
                    if (b != sig_byte(pos[3:0])) begin
                        count_next = base_cnt;
                        phase_next = PH_FIN;
                        res_valid = 1'b1;
                        res_data.status = ST_NOT_PROXY;
                    end
                end else if (pos == 17'd12) begin
                    cmd_next = b[3:0];
                    vbad_next = (b[7:4] != 4'h2);
                end else if (pos == 17'd13) begin
                    fam_next = b[7:4];
                end else if (pos == 17'd14) begin
                    blen_next = {b, 8'h00};
                end else begin
                    blen_next = {blen_next[15:8], b};
                    if (vbad_next) begin
                        phase_next = PH_FIN;
                        res_valid = 1'b1;
                        res_data.status = ST_INVALID;
                        res_data.version = VER_BINARY;
                    end else if (blen_next == 16'd0) begin
                        phase_next = PH_FIN;
                        res_valid = 1'b1;
                    end else begin
                        phase_next = PH_V2_BLOCK;
                    end
                end
            end else begin
                count_next = cnt_inc;
                if (off < 17'd16) begin
                    wr_en = 1'b1;
                    wr_idx = off[3:0];
                end
                if (off == 17'd8) p4_next = {b, 8'h00};
                else if (off == 17'd9) p4_next = {p4_reg[15:8], b};
                else if (off == 17'd32) p6_next = {b, 8'h00};
                else if (off == 17'd33) p6_next = {p6_reg[15:8], b};
                if (cnt_inc >= v2_len) begin
                    phase_next = PH_FIN;
                    res_valid = 1'b1;
                end
            end
        end
        // binary done verdict
        if (res_valid && res_data.status == ST_DONE && res_data.version == VER_UNKNOWN) begin
            res_data.version = VER_BINARY;
            res_data.header_length = v2_len;
            if (cmd_next == 4'h1 && fam_next == 4'h1 && blen_next >= 16'd12) begin
                res_data.addr_kind = KIND_V4;
                res_data.addr_high = {pk_hi[63:32], 32'd0};
                if (wr_en && wr_idx < 4'd4) res_data.addr_high[63 - 8*wr_idx -: 8] = b;
                res_data.src_port = p4_next;
            end else if (cmd_next == 4'h1 && fam_next == 4'h2 && blen_next >= 16'd36) begin
                res_data.addr_kind = KIND_V6;
                res_data.addr_high = pk_hi;
                res_data.addr_low = pk_lo;
                res_data.src_port = p6_next;
            end
        end
        fidx_next = fi; pm_next = pm; tst_next = ts; tln_next = tl;
        pacc_next = acc; povf_next = ovf; pdone_next = dn;
    end

    always_ff @(posedge aclk) begin
        if (in_valid && wr_en) addr_reg[wr_idx] <= b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0; cr_reg <= 1'b0; cmd_reg <= '0; fam_reg <= '0;
            vbad_reg <= 1'b0; blen_reg <= '0; p4_reg <= '0; p6_reg <= '0;
            fidx_reg <= '0; pm_reg <= '0; tst_reg <= '0; tln_reg <= '0;
            pacc_reg <= '0; povf_reg <= 1'b0; pdone_reg <= 1'b0;
        end else if (in_valid) begin
            phase_reg <= phase_next;
            count_reg <= count_next; cr_reg <= cr_next; cmd_reg <= cmd_next;
            fam_reg <= fam_next; vbad_reg <= vbad_next; blen_reg <= blen_next;
            p4_reg <= p4_next; p6_reg <= p6_next;
            fidx_reg <= fidx_next; pm_reg <= pm_next; tst_reg <= tst_next;
            tln_reg <= tln_next; pacc_reg <= pacc_next; povf_reg <= povf_next;
            pdone_reg <= pdone_next;
        end
    end

endmodule

// ----- rtl/proxy_protocol_header_parser.sv -----
// top level of the proxy protocol header parser
// uses pph_pkg and pph_core; input register, parse logic, result register
// One byte is taken per cycle with s_valid/s_ready; s_payload.start_req marks the
// first byte of a connection. Each connection gives one verdict on m_payload, with
// m_valid rising as the deciding byte's verdict enters the result register; bytes after a
// verdict and before the next start give nothing. Bytes can follow back to back, one
// per cycle, set by the single parse step between the input and result registers;
// the input stalls only while an unread verdict waits and the next byte also decides.
module proxy_protocol_header_parser import pph_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pph_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output pph_out_t m_payload
);

    logic     in_vld_reg;
    pph_in_t  in_reg;
    logic     res_valid;
    pph_out_t res_data;
    logic     out_vld_reg;
    pph_out_t out_reg;
    logic     adv;

    // the parse step runs only when its result, if any, can be stored
    assign adv = !out_vld_reg || m_ready || !res_valid;
    assign s_ready = !in_vld_reg || adv;

    pph_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_vld_reg && adv),
        .in_data  (in_reg),
        .res_valid(res_valid),
        .res_data (res_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_ready) in_vld_reg <= s_valid;
            if (in_vld_reg && adv && res_valid) out_vld_reg <= 1'b1;
            else if (m_ready) out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_reg <= s_payload;
        if (in_vld_reg && adv && res_valid) out_reg <= res_data;
    end

    assign m_valid = out_vld_reg;
    assign m_payload = out_reg;

endmodule

// ----- rtl/pph_checker.sv -----
// port checker for the proxy protocol header parser
// depends on pph_pkg; bound to proxy_protocol_header_parser
module pph_checker import pph_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input pph_out_t m_payload
);

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
            m_valid && !m_ready |=> m_valid && $stable(m_payload);
    endproperty
    a_hold: assert property (p_hold) else $error("result dropped while stalled");

    property p_status;
        @(posedge aclk) disable iff (!aresetn)
            m_valid |-> m_payload.status <= ST_NOT_PROXY;
    endproperty
    a_status: assert property (p_status) else $error("bad status code");

    property p_notproxy;
        @(posedge aclk) disable iff (!aresetn)
            m_valid && m_payload.status == ST_NOT_PROXY |->
                m_payload.version == VER_UNKNOWN && m_payload.header_length == 17'd0;
    endproperty
    a_notproxy: assert property (p_notproxy) else $error("not proxy fields nonzero");

    property p_reset;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_reset: assert property (p_reset) else $error("valid after reset");

    property p_req_hold;
        @(posedge aclk) disable iff (!aresetn)
            s_valid && !s_ready |=> s_valid;
    endproperty
    a_req_hold: assert property (p_req_hold) else $error("request dropped while stalled");

endmodule

bind proxy_protocol_header_parser pph_checker u_pph_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_payload(m_payload)
);
